/* rtl/core/clfa_pkg.sv */
// shared types, codes and constants for the crlf line assembly fifo
package clfa_pkg;

   // default ring size in bytes
   localparam int unsigned DEPTH_DEFAULT = 1024;

   // widths fixed by the payload
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned LINES_W  = 10;

   // line counter saturates here
   localparam logic [LINES_W-1:0] LINE_MAX = LINES_W'(1023);

   // result status codes
   localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CHAR    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EOL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOLINE  = 3'd4;

   // character codes
   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

   // request command codes
   typedef enum logic {
      OP_PUT = 1'b0,
      OP_POP = 1'b1
   } op_type;

   // classified request passed from front to back
   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] data;
      logic              is_cr;
      logic              is_lf;
   } entry_type;

   // bytes handed back by a pop
   function automatic logic is_kept(input logic [BYTE_W-1:0] c);
      return (c == CH_TAB) || ((c >= CH_SPACE) && (c != CH_DEL));
   endfunction

endpackage

/* rtl/core/clfa_if.sv */
// request and response channel interfaces
interface clfa_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface clfa_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] char_out;
   logic [9:0] lines_ready;

   modport source (output valid, output status, output char_out, output lines_ready,
                   input ready);
   modport sink   (input valid, input status, input char_out, input lines_ready,
                   output ready);
endinterface

/* rtl/core/clfa_front.sv */
// request front end: accept, classify and queue requests for the back end
module clfa_front (
   input  logic                clock,
   input  logic                reset,
   clfa_req_if.sink            req_chan,
   output logic                q_valid,
   output clfa_pkg::entry_type q_entry,
   input  logic                q_ready
);

   clfa_pkg::entry_type slot_ff [2];
   logic [1:0]          cnt_ff, cnt_in;
   logic                wr_idx_ff, wr_idx_in;
   logic                rd_idx_ff, rd_idx_in;
   clfa_pkg::entry_type new_entry;
   logic                push, pop;

   // classify the incoming request
   always_comb begin
      new_entry.op    = req_chan.cmd ? clfa_pkg::OP_POP : clfa_pkg::OP_PUT;
      new_entry.data  = req_chan.data_byte;
      new_entry.is_cr = (req_chan.data_byte == clfa_pkg::CH_CR);
      new_entry.is_lf = (req_chan.data_byte == clfa_pkg::CH_LF);
   end

   // two-entry queue handshake
   assign req_chan.ready = (cnt_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (cnt_ff != 2'd0);
   assign q_entry        = slot_ff[rd_idx_ff];
   assign pop            = q_valid && q_ready;

   // occupancy and index update
   always_comb begin
      wr_idx_in = push ? ~wr_idx_ff : wr_idx_ff;
      rd_idx_in = pop ? ~rd_idx_ff : rd_idx_ff;
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_idx_ff <= 1'b0;
         rd_idx_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_idx_ff] <= new_entry;
      end
   end

endmodule

/* rtl/core/clfa_back.sv */
// back end: byte ring, line counting, pop sequencer and result register
module clfa_back #(
   parameter int unsigned DEPTH = clfa_pkg::DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  clfa_pkg::entry_type q_entry,
   output logic                q_ready,
   clfa_rsp_if.source          rsp_chan
);

   localparam int unsigned PTR_W  = $clog2(DEPTH);
   localparam int unsigned FILL_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_FETCH = 3'b010,
      S_EVAL  = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic [PTR_W-1:0]                 wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                 rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]                fill_ff, fill_in;
   logic [clfa_pkg::LINES_W-1:0]     lines_ff, lines_in;
   logic                             wsaw_ff, wsaw_in;
   logic                             rsaw_ff, rsaw_in;
   logic [clfa_pkg::BYTE_W-1:0]      rd_data_ff;
   logic                             out_valid_ff, out_valid_in;
   logic [clfa_pkg::STATUS_W-1:0]    out_status_ff, out_status_in;
   logic [clfa_pkg::BYTE_W-1:0]      out_char_ff, out_char_in;
   logic [clfa_pkg::LINES_W-1:0]     out_lines_ff;
   logic                             done;
   logic                             mem_we;
   logic                             mem_re;
   logic                             prev_cr;
   logic [clfa_pkg::BYTE_W-1:0]      byte_store_mem [DEPTH];

   // a new item starts only in idle with the result register free or draining
   assign q_ready = (state_ff == S_IDLE) && (!out_valid_ff || rsp_chan.ready);

   assign prev_cr = wsaw_ff && (fill_ff != '0);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      fill_in       = fill_ff;
      lines_in      = lines_ff;
      wsaw_in       = wsaw_ff;
      rsaw_in       = rsaw_ff;
      done          = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      out_status_in = clfa_pkg::ST_NOLINE;
      out_char_in   = clfa_pkg::CH_NUL;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && q_ready) begin
               if (q_entry.op == clfa_pkg::OP_PUT) begin
                  done = 1'b1;
                  if (fill_ff == FILL_FULL) begin
                     out_status_in = clfa_pkg::ST_DROPPED;
                  end else begin
                     mem_we        = 1'b1;
                     out_status_in = clfa_pkg::ST_STORED;
                     if (prev_cr && q_entry.is_lf && (lines_ff < clfa_pkg::LINE_MAX)) begin
                        lines_in = lines_ff + clfa_pkg::LINES_W'(1);
                     end
                     wsaw_in   = q_entry.is_cr;
                     wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
                     fill_in   = fill_ff + FILL_W'(1);
                  end
               end else if (lines_ff == '0) begin
                  done = 1'b1;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            // read the oldest byte, or give up on an empty ring
            if (fill_ff == '0) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               mem_re   = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            // consume the fetched byte and decide
            rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
            fill_in   = fill_ff - FILL_W'(1);
            if (rsaw_ff && (rd_data_ff == clfa_pkg::CH_LF)) begin
               rsaw_in       = 1'b0;
               lines_in      = lines_ff - clfa_pkg::LINES_W'(1);
               out_status_in = clfa_pkg::ST_EOL;
               done          = 1'b1;
               state_in      = S_IDLE;
            end else begin
               rsaw_in = (rd_data_ff == clfa_pkg::CH_CR);
               if (clfa_pkg::is_kept(rd_data_ff)) begin
                  out_status_in = clfa_pkg::ST_CHAR;
                  out_char_in   = rd_data_ff;
                  done          = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register valid
   always_comb begin
      priority if (done) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         lines_ff     <= '0;
         wsaw_ff      <= 1'b0;
         rsaw_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         lines_ff     <= lines_in;
         wsaw_ff      <= wsaw_in;
         rsaw_ff      <= rsaw_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (done) begin
         out_status_ff <= out_status_in;
         out_char_ff   <= out_char_in;
         out_lines_ff  <= lines_in;
      end
   end

   // byte ring write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         byte_store_mem[wr_ptr_ff] <= q_entry.data;
      end
   end

   // byte ring registered read port
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= byte_store_mem[rd_ptr_ff];
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_status_ff;
   assign rsp_chan.char_out    = out_char_ff;
   assign rsp_chan.lines_ready = out_lines_ff;

endmodule

/* rtl/core/crlf_line_assembly_fifo.sv */
// top level of the crlf line assembly fifo
//
//  channel   | dir | payload                          | transfer when
//  ----------+-----+----------------------------------+---------------------
//  req_chan  | in  | cmd, data_byte                   | valid && ready
//  rsp_chan  | out | status, char_out, lines_ready    | valid && ready
//
// a put is handled in idle; a pop passes through a registered ring read (fetch)
// and an evaluate step for each byte it walks, until a kept character, an end of
// line or an empty ring ends it.
// reset clears pointers, fill level, line count and control; the byte ring is
// not cleared and needs no clearing pass.
// a two-entry request queue and a result register decouple both sides: requests
// keep being taken, until the queue is full, while a result waits for its transfer.
module crlf_line_assembly_fifo #(
   parameter int unsigned DEPTH = clfa_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   clfa_req_if.sink   req_chan,
   clfa_rsp_if.source rsp_chan
);

   logic                q_valid;
   logic                q_ready;
   clfa_pkg::entry_type q_entry;

   // request accept and classification
   clfa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_ready  (q_ready)
   );

   // ring buffer and pop sequencer
   clfa_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_ready  (q_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

/* verif/tb_top.sv */
// self-checking testbench for the crlf line assembly fifo
module tb_top;
   import clfa_pkg::*;

   localparam int DEPTH      = DEPTH_DEFAULT;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int N_PROBE    = 25;
   localparam int N_RANDOM   = 525;
   localparam int N_CALM     = 80;
   localparam int HOLD_AT    = 60;
   localparam int HOLD_LEN   = 400;
   localparam int TAIL_WAIT  = 40;
   localparam int MAX_REPORT = 10;

   // one result of the block
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   ch;
      logic [LINES_W-1:0]  lines;
   } line_result_type;

   // result typed in by hand for a directed row
   typedef struct packed {
      logic            typed;
      line_result_type want;
   } pin_type;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] b;
      pin_type           pin;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   clfa_req_if req_if ();
   clfa_rsp_if rsp_if ();

   crlf_line_assembly_fifo #(.DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #10 clock = ~clock;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   // directed rows: empty buffer, lone lf, every byte class, crlf framing
   probe_row_type probe_rows [N_PROBE] = '{
      '{OP_POP, CH_NUL,   '{1'b1, '{ST_NOLINE, CH_NUL, 10'd0}}},
      '{OP_PUT, CH_LF,    '{1'b1, '{ST_STORED, CH_NUL, 10'd0}}},
      '{OP_POP, 8'hFF,    '{1'b1, '{ST_NOLINE, CH_NUL, 10'd0}}},
      '{OP_PUT, 8'h41,    '0},
      '{OP_PUT, CH_TAB,   '0},
      '{OP_PUT, CH_NUL,   '0},
      '{OP_PUT, 8'h1F,    '0},
      '{OP_PUT, CH_DEL,   '0},
      '{OP_PUT, 8'h80,    '0},
      '{OP_PUT, 8'hFF,    '0},
      '{OP_PUT, CH_SPACE, '0},
      '{OP_PUT, CH_CR,    '0},
      '{OP_PUT, CH_CR,    '0},
      '{OP_PUT, CH_LF,    '{1'b1, '{ST_STORED, CH_NUL, 10'd1}}},
      '{OP_POP, CH_NUL,   '{1'b1, '{ST_CHAR, 8'h41, 10'd1}}},
      '{OP_POP, CH_NUL,   '{1'b1, '{ST_CHAR, CH_TAB, 10'd1}}},
      '{OP_POP, CH_NUL,   '{1'b1, '{ST_CHAR, 8'h80, 10'd1}}},
      '{OP_POP, CH_NUL,   '{1'b1, '{ST_CHAR, 8'hFF, 10'd1}}},
      '{OP_POP, CH_NUL,   '{1'b1, '{ST_CHAR, CH_SPACE, 10'd1}}},
      '{OP_POP, CH_NUL,   '{1'b1, '{ST_EOL, CH_NUL, 10'd0}}},
      '{OP_POP, CH_NUL,   '{1'b1, '{ST_NOLINE, CH_NUL, 10'd0}}},
      '{OP_PUT, CH_CR,    '0},
      '{OP_PUT, 8'h42,    '0},
      '{OP_PUT, CH_LF,    '{1'b1, '{ST_STORED, CH_NUL, 10'd0}}},
      '{OP_POP, CH_NUL,   '{1'b1, '{ST_NOLINE, CH_NUL, 10'd0}}}
   };

   // line assembly state as the testbench sees it
   logic [BYTE_W-1:0] ring_mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr = '0;
   logic [PTR_W-1:0]  rd_ptr = '0;
   int unsigned       ring_fill = 0;
   int unsigned       line_total = 0;
   bit                wr_after_cr = 1'b0;
   bit                rd_after_cr = 1'b0;

   line_result_type owed_results [$];
   pin_type         pinned_q [$];
   int              n_items_taken;
   int              n_results_seen = 0;
   int              n_errors = 0;
   logic            quiet;
   int              send_mode;
   int              send_mode_left;

   // next result of the line assembler for one request
   function automatic line_result_type assemble_step(input op_type op,
                                                     input logic [BYTE_W-1:0] b);
      line_result_type r;
      logic [BYTE_W-1:0] c;
      bit done;
      r = '{ST_NOLINE, CH_NUL, '0};
      done = 1'b0;
      if (op == OP_PUT) begin
         if (ring_fill >= DEPTH) begin
            r.status = ST_DROPPED;
         end else begin
            // lf after a held cr closes a line
            if (wr_after_cr && ring_fill != 0 && b == CH_LF && line_total < 32'(LINE_MAX))
               line_total++;
            ring_mem[wr_ptr] = b;
            wr_after_cr = (b == CH_CR);
            wr_ptr = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
            ring_fill++;
            r.status = ST_STORED;
         end
      end else if (line_total != 0) begin
         // walk over filtered bytes up to a kept one or the end of line
         while (!done && ring_fill != 0) begin
            c = ring_mem[rd_ptr];
            rd_ptr = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
            ring_fill--;
            if (rd_after_cr && c == CH_LF) begin
               rd_after_cr = 1'b0;
               line_total--;
               r.status = ST_EOL;
               done = 1'b1;
            end else begin
               rd_after_cr = (c == CH_CR);
               if (c == CH_TAB || (c >= CH_SPACE && c != CH_DEL)) begin
                  r.ch = c;
                  r.status = ST_CHAR;
                  done = 1'b1;
               end
            end
         end
      end
      r.lines = line_total[LINES_W-1:0];
      return r;
   endfunction

   // text byte with a bias toward the classes the filter cares about
   function automatic logic [BYTE_W-1:0] pick_line_byte();
      int unsigned k;
      logic [BYTE_W-1:0] b;
      k = $urandom_range(0, 99);
      if (k < 45)      b = 8'($urandom_range(8'h20, 8'h7E));
      else if (k < 55) b = CH_TAB;
      else if (k < 65) b = 8'($urandom_range(8'h00, 8'h1F));
      else if (k < 72) b = CH_DEL;
      else if (k < 87) b = 8'($urandom_range(8'h80, 8'hFF));
      else if (k < 92) b = CH_CR;
      else             b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   // offer one request and hold it until the transfer
   task automatic push_item(input op_type op, input logic [BYTE_W-1:0] b,
                            input pin_type pin = '0);
      if (!quiet) begin
         if (send_mode_left == 0) begin
            send_mode = $urandom_range(0, 2);
            send_mode_left = 40;
         end
         send_mode_left--;
         if ((send_mode == 1 && $urandom_range(0, 7) == 0) ||
             (send_mode == 2 && $urandom_range(0, 2) == 0)) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
      pinned_q.push_back(pin);
      req_if.valid     <= 1'b1;
      req_if.cmd       <= op;
      req_if.data_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      n_items_taken++;
   endtask

   // sender stops until every owed result has come back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (n_results_seen != n_items_taken) @(posedge clock);
   endtask

   // request side capture and result check
   always @(posedge clock) begin : scoreboard
      line_result_type want;
      line_result_type got;
      pin_type pin;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            want = assemble_step(op_type'(req_if.cmd), req_if.data_byte);
            if (pinned_q.size() != 0) begin
               pin = pinned_q.pop_front();
               if (pin.typed) want = pin.want;
            end
            owed_results.push_back(want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.status, rsp_if.char_out, rsp_if.lines_ready};
            if (owed_results.size() == 0) begin
               n_errors++;
               if (n_errors <= MAX_REPORT)
                  $display("unexpected result: status %0d char %02h lines %0d",
                           got.status, got.ch, got.lines);
            end else begin
               want = owed_results.pop_front();
               n_results_seen <= n_results_seen + 1;
               if (got.status !== want.status || got.ch !== want.ch ||
                   got.lines !== want.lines) begin
                  n_errors++;
                  if (n_errors <= MAX_REPORT)
                     $display("mismatch: status %0d/%0d char %02h/%02h lines %0d/%0d",
                              want.status, got.status, want.ch, got.ch,
                              want.lines, got.lines);
               end
            end
         end
      end
   end

   // receiver: random stall bursts and one long hold-off
   initial begin : result_sink
      int rcv_mode;
      int rcv_mode_left;
      bit long_hold_done;
      rcv_mode = 0;
      rcv_mode_left = 0;
      long_hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rcv_mode_left == 0) begin
            rcv_mode = $urandom_range(0, 2);
            rcv_mode_left = 40;
         end
         rcv_mode_left--;
         if (!long_hold_done && n_results_seen >= HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
         end else if (!quiet && ((rcv_mode == 1 && $urandom_range(0, 7) == 0) ||
                                 (rcv_mode == 2 && $urandom_range(0, 2) == 0))) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // stimulus
   initial begin : line_source
      int start;
      int sel;
      req_if.valid     <= 1'b0;
      req_if.cmd       <= OP_PUT;
      req_if.data_byte <= CH_NUL;
      quiet            <= 1'b0;
      n_items_taken = 0;
      send_mode = 0;
      send_mode_left = 0;
      while (reset) @(posedge clock);

      // directed rows
      for (int i = 0; i < N_PROBE; i++)
         push_item(probe_rows[i].op, probe_rows[i].b, probe_rows[i].pin);

      // let every directed result come back before the random part
      wait_drained();

      // random traffic: framed lines, runs of pops, some broken framing and noise
      start = n_items_taken;
      while (n_items_taken - start < N_RANDOM) begin
         if (n_items_taken - start >= N_RANDOM - N_CALM) quiet <= 1'b1;
         sel = $urandom_range(0, 99);
         if (sel < 50) begin
            repeat ($urandom_range(0, 14)) push_item(OP_PUT, pick_line_byte());
            push_item(OP_PUT, CH_CR);
            push_item(OP_PUT, CH_LF);
         end else if (sel < 85) begin
            repeat ($urandom_range(1, 20)) push_item(OP_POP, 8'($urandom_range(0, 255)));
         end else if (sel < 92) begin
            case ($urandom_range(0, 2))
               0: begin
                  push_item(OP_PUT, CH_CR);
                  push_item(OP_PUT, pick_line_byte());
               end
               1: push_item(OP_PUT, CH_LF);
               default: begin
                  push_item(OP_PUT, CH_CR);
                  push_item(OP_PUT, CH_CR);
                  push_item(OP_PUT, CH_LF);
               end
            endcase
         end else begin
            repeat ($urandom_range(1, 6)) push_item(OP_PUT, 8'($urandom_range(0, 255)));
         end
      end

      // wrap up
      wait_drained();
      repeat (TAIL_WAIT) @(posedge clock);
      if (n_errors == 0 && owed_results.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/clfa_pkg.sv
rtl/core/clfa_if.sv
rtl/core/clfa_front.sv
rtl/core/clfa_back.sv
rtl/core/crlf_line_assembly_fifo.sv
verif/tb_top.sv
